>>> design/ptma_pkg.sv
// Package for the point trail moving average block.
// Holds the item structs, sizing constants and the divider handshake types.
// No dependencies.
package ptma_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int COORD_BITS = 12;

	// Width of the window size register and of the reported count
	localparam int CFG_BITS   = 5;
	localparam int COUNT_BITS = 5;

	// Internal sizing derived from the window depth
	localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS  = COORD_BITS + CNT_BITS;

	typedef struct packed {
		logic                  kind;
		logic [COORD_BITS-1:0] x_coord;
		logic [COORD_BITS-1:0] y_coord;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] avg_x;
		logic [COORD_BITS-1:0] avg_y;
		logic [COUNT_BITS-1:0] point_count;
		logic                  avg_valid;
	} out_item_t;

	// Input kind codes
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_MISS = 1'b1;

	typedef struct packed {
		logic                start;
		logic [SUM_BITS-1:0] dividend;
		logic [CNT_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [SUM_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

>>> design/point_trail_moving_average.sv
// Point trail moving average: top level with sequencer, point store and sums.
// Depends on ptma_pkg, ptma_ram and ptma_div.
//
// Each accepted item either adds a point (kind 0) or reports a missed
// detection (kind 1), and yields exactly one result item: the truncated mean
// of the stored x and y positions and the number of stored points. The store
// is a ring of MAX_WINDOW entries in a RAM; running sums are kept so only
// the evicted point has to be read back. One serial divider produces the x
// mean and then the y mean, one quotient bit per cycle. For an item with a
// non-empty window after its update, almost all of the time from accept to
// the next accept goes to the two divider passes; an item that leaves the
// window empty skips the divider. in_ready is high only while the sequencer
// is idle. The result sits in an output register, so the next item can be
// accepted while the previous result still waits for out_ready. Writing
// window_size empties the window; values above MAX_WINDOW act as MAX_WINDOW
// and zero keeps the window empty. Reset sets window_size to 10 and empties
// the window.
module point_trail_moving_average (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ptma_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ptma_pkg::out_item_t                out_data,
	input  logic                               cfg_wr_en,
	input  logic [ptma_pkg::CFG_BITS-1:0]      cfg_wr_data
);
	import ptma_pkg::*;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_DX   = 3'd2;
	localparam logic [2:0] S_WX   = 3'd3;
	localparam logic [2:0] S_DY   = 3'd4;
	localparam logic [2:0] S_WY   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [CFG_BITS-1:0]  WINDOW_RESET = CFG_BITS'(10);
	localparam logic [SLOT_BITS-1:0] SLOT_LAST    = SLOT_BITS'(MAX_WINDOW - 1);

	logic [2:0]            state_q;
	logic [CFG_BITS-1:0]   win_q;
	logic [SLOT_BITS-1:0]  oldest_q;
	logic [CNT_BITS-1:0]   fill_q;
	logic [SUM_BITS-1:0]   sum_x_q;
	logic [SUM_BITS-1:0]   sum_y_q;
	logic                  out_valid_q;

	// Captured item and divider results (payload, no reset)
	logic                  kind_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [COORD_BITS-1:0] ax_q;
	logic [COORD_BITS-1:0] ay_q;
	out_item_t             out_data_q;

	logic                    accept;
	logic [CNT_BITS-1:0]     lim;
	logic                    drop;
	logic                    app;
	logic [CNT_BITS-1:0]     fill_mid;
	logic [SLOT_BITS-1:0]    oldest_mid;
	logic [CNT_BITS:0]       slot_sum;
	logic [SLOT_BITS-1:0]    wr_slot;
	logic [2*COORD_BITS-1:0] rd_data;
	logic [COORD_BITS-1:0]   old_x;
	logic [COORD_BITS-1:0]   old_y;
	logic [SUM_BITS-1:0]     sum_x_nxt;
	logic [SUM_BITS-1:0]     sum_y_nxt;
	logic                    res_free;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign res_free = !out_valid_q || out_ready;

	// Clamp the window size to the store depth
	always_comb begin
		if (32'(win_q) > MAX_WINDOW) begin
			lim = CNT_BITS'(MAX_WINDOW);
		end else begin
			lim = CNT_BITS'(win_q);
		end
	end

	// Window update: evict the oldest point when full or on a miss, then append
	always_comb begin
		old_x      = rd_data[2*COORD_BITS-1:COORD_BITS];
		old_y      = rd_data[COORD_BITS-1:0];
		drop       = (fill_q != '0) && ((kind_q == KIND_MISS) || (fill_q >= lim));
		fill_mid   = fill_q - CNT_BITS'(drop);
		app        = (kind_q == KIND_ADD) && (fill_mid < lim);
		oldest_mid = oldest_q;
		if (drop) begin
			oldest_mid = (oldest_q == SLOT_LAST) ? '0 : oldest_q + 1'b1;
		end
		slot_sum = (CNT_BITS+1)'(oldest_mid) + (CNT_BITS+1)'(fill_mid);
		if (32'(slot_sum) >= MAX_WINDOW) begin
			slot_sum = slot_sum - (CNT_BITS+1)'(MAX_WINDOW);
		end
		wr_slot   = slot_sum[SLOT_BITS-1:0];
		sum_x_nxt = sum_x_q - (drop ? SUM_BITS'(old_x) : '0) + (app ? SUM_BITS'(x_q) : '0);
		sum_y_nxt = sum_y_q - (drop ? SUM_BITS'(old_y) : '0) + (app ? SUM_BITS'(y_q) : '0);
	end

	// Read port always points at the oldest slot; data is ready in S_UPD
	ptma_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk     (clk),
		.wr_en   ((state_q == S_UPD) && app),
		.wr_addr (wr_slot),
		.wr_data ({x_q, y_q}),
		.rd_addr (oldest_q),
		.rd_data (rd_data)
	);

	// Feed the shared divider: x sum first, then y sum
	always_comb begin
		div_req.start    = (state_q == S_DX && fill_q != '0) || (state_q == S_DY);
		div_req.dividend = (state_q == S_DY) ? sum_y_q : sum_x_q;
		div_req.divisor  = fill_q;
	end

	ptma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= WINDOW_RESET;
			oldest_q    <= '0;
			fill_q      <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the taken result unless a new one loads in its place
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					oldest_q <= oldest_mid;
					fill_q   <= fill_mid + CNT_BITS'(app);
					sum_x_q  <= sum_x_nxt;
					sum_y_q  <= sum_y_nxt;
					state_q  <= S_DX;
				end
				S_DX: begin
					// Skip the divider when the window is empty
					state_q <= (fill_q == '0) ? S_OUT : S_WX;
				end
				S_WX: begin
					if (div_rsp.done) begin
						state_q <= S_DY;
					end
				end
				S_DY: begin
					state_q <= S_WY;
				end
				S_WY: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold until the output register is free
					if (res_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Register write empties the window
			if (cfg_wr_en) begin
				win_q    <= cfg_wr_data;
				oldest_q <= '0;
				fill_q   <= '0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
			end
		end
	end

	// Payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_data.kind;
			x_q    <= in_data.x_coord;
			y_q    <= in_data.y_coord;
		end
		if (state_q == S_WX && div_rsp.done) begin
			ax_q <= div_rsp.quotient[COORD_BITS-1:0];
		end
		if (state_q == S_WY && div_rsp.done) begin
			ay_q <= div_rsp.quotient[COORD_BITS-1:0];
		end
		if (state_q == S_OUT && res_free) begin
			out_data_q.avg_valid   <= (fill_q != '0);
			out_data_q.avg_x       <= (fill_q != '0) ? ax_q : '0;
			out_data_q.avg_y       <= (fill_q != '0) ? ay_q : '0;
			out_data_q.point_count <= COUNT_BITS'(fill_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> design/ptma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module ptma_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> design/ptma_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ptma_pkg for widths and the request/response structs.
module ptma_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ptma_pkg::div_req_t req,
	output ptma_pkg::div_rsp_t rsp
);
	import ptma_pkg::*;

	localparam int STEP_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;
	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SUM_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [CNT_BITS-1:0]  rem_q;
	logic [SUM_BITS-1:0]  quo_q;
	logic [CNT_BITS-1:0]  dvs_q;

	logic [CNT_BITS:0] rem_sh;
	logic [CNT_BITS:0] rem_sub;
	logic              fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[SUM_BITS-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// Shift in the next dividend bit, subtract when it fits
			rem_q <= fits ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> design/ptma_checker.sv
// Port-level checks for the point trail moving average block, with bind.
// Depends on ptma_pkg and point_trail_moving_average.
module ptma_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input ptma_pkg::out_item_t           out_data
);
	import ptma_pkg::*;

	// One item at a time: drop ready right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high the cycle after an accepted item");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or vanished");

	// Valid flag follows the count; an empty window reports zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.avg_valid == (out_data.point_count != '0)) &&
			(out_data.avg_valid || (out_data.avg_x == '0 && out_data.avg_y == '0)))
		else $error("avg_valid or empty-window averages inconsistent");

	// Count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_data.point_count) <= MAX_WINDOW)
		else $error("point_count above store depth");

endmodule

bind point_trail_moving_average ptma_checker u_ptma_checker (.*);
